// File: design/vm2_pkg.sv
// vm2_pkg: widths and payload types for the 2-d vector magnitude block
// no dependencies; imported by the channel interfaces and every module
package vm2_pkg;

   // component width, two's complement
   localparam int IN_W  = 32;
   // width of one square and of the sum of two squares
   localparam int SUM_W = 2 * IN_W;
   // partial remainder of the root recurrence
   localparam int REM_W = IN_W + 2;
   // result field width
   localparam int MAG_W = 32;

   // one digit of the root per cell
   localparam int CELL_COUNT = IN_W;

   // data handed from cell to cell
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [IN_W-1:0]  root;
      logic [SUM_W-1:0] rad;
   } root_step_type;

endpackage

// File: design/vm2_if.sv
// vm2_if: valid/ready channels for components in and magnitude out
// depends on vm2_pkg
interface vm2_req_if;
   import vm2_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] x_value;
   logic signed [IN_W-1:0] y_value;

   modport source (output valid, output x_value, output y_value, input ready);
   modport sink (input valid, input x_value, input y_value, output ready);
endinterface

interface vm2_rsp_if;
   import vm2_pkg::*;

   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;

   modport source (output valid, output magnitude, input ready);
   modport sink (input valid, input magnitude, output ready);
endinterface

// File: design/vm2_square.sv
// vm2_square: absolute values and squares, then the sum of squares
// two register stages with valid/ready; depends on vm2_pkg
module vm2_square (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [vm2_pkg::IN_W-1:0] x_value,
   input  logic signed [vm2_pkg::IN_W-1:0] y_value,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [vm2_pkg::SUM_W-1:0]       out_sum
);
   import vm2_pkg::*;

   logic [IN_W-1:0]  abs_x;
   logic [IN_W-1:0]  abs_y;
   logic [SUM_W-1:0] sq_x_in;
   logic [SUM_W-1:0] sq_y_in;
   logic [SUM_W-1:0] sq_x_ff;
   logic [SUM_W-1:0] sq_y_ff;
   logic             sq_valid_ff;
   logic             sq_ready;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] sum_ff;
   logic             sum_valid_ff;

   // magnitudes; the most negative value maps to 2^(IN_W-1) unsigned
   assign abs_x = x_value[IN_W-1] ? (IN_W'(0) - IN_W'(x_value)) : IN_W'(x_value);
   assign abs_y = y_value[IN_W-1] ? (IN_W'(0) - IN_W'(y_value)) : IN_W'(y_value);

   // one multiplier per component
   assign sq_x_in = SUM_W'(abs_x) * SUM_W'(abs_x);
   assign sq_y_in = SUM_W'(abs_y) * SUM_W'(abs_y);

   // sum of two squares stays below 2^(SUM_W-1)+1, fits SUM_W bits
   assign sum_in = sq_x_ff + sq_y_ff;

   // stage ready: empty or draining
   assign in_ready = !sq_valid_ff || sq_ready;
   assign sq_ready = !sum_valid_ff || out_ready;

   // square stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else if (in_ready) begin
         sq_valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
      end
   end

   // sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (sq_ready) begin
         sum_valid_ff <= sq_valid_ff;
      end
      if (sq_ready && sq_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = sum_valid_ff;
   assign out_sum   = sum_ff;

endmodule

// File: design/vm2_cell.sv
// vm2_cell: one digit of the bitwise square root recurrence, registered
// depends on vm2_pkg
module vm2_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  vm2_pkg::root_step_type in_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output vm2_pkg::root_step_type out_data
);
   import vm2_pkg::*;

   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;
   logic             take_bit;
   root_step_type    data_in;
   root_step_type    data_ff;
   logic             valid_ff;

   // bring down the next two radicand bits, try root*4+1
   assign rem_shift = {in_data.rem[REM_W-3:0], in_data.rad[SUM_W-1 -: 2]};
   assign trial     = {in_data.root, 2'b01};
   assign take_bit  = rem_shift >= trial;

   always_comb begin
      data_in.rem  = take_bit ? (rem_shift - trial) : rem_shift;
      data_in.root = {in_data.root[IN_W-2:0], take_bit};
      data_in.rad  = {in_data.rad[SUM_W-3:0], 2'b00};
   end

   assign in_ready = !valid_ff || out_ready;

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: design/vector_magnitude_2d.sv
// vector_magnitude_2d: floor(sqrt(x*x + y*y)) of two signed Q16.16 components
// stages in order: square stage, sum stage, then one cell per root bit
// one transfer per cycle unless rsp_bus stalls; every stage has its own register and ready
// the last cell holds a waiting result; input stalls once every stage behind it is full
// synchronous active-high reset empties all stages; no other state
// depends on vm2_pkg, vm2_if, vm2_square, vm2_cell
module vector_magnitude_2d (
   input  logic  clock,
   input  logic  reset,
   vm2_req_if.sink   req_bus,
   vm2_rsp_if.source rsp_bus
);
   import vm2_pkg::*;

   logic             sum_valid;
   logic             sum_ready;
   logic [SUM_W-1:0] sum_value;

   logic          cell_valid [CELL_COUNT+1];
   logic          cell_ready [CELL_COUNT+1];
   root_step_type cell_data  [CELL_COUNT+1];

   // squares and their sum
   vm2_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .x_value   (req_bus.x_value),
      .y_value   (req_bus.y_value),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sum_value)
   );

   // head of the root chain starts with zero remainder and root
   assign cell_valid[0]     = sum_valid;
   assign sum_ready         = cell_ready[0];
   assign cell_data[0].rem  = '0;
   assign cell_data[0].root = '0;
   assign cell_data[0].rad  = sum_value;

   // chain of root cells, one result bit each, most significant first
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      vm2_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cell_valid[i]),
         .in_ready  (cell_ready[i]),
         .in_data   (cell_data[i]),
         .out_valid (cell_valid[i+1]),
         .out_ready (cell_ready[i+1]),
         .out_data  (cell_data[i+1])
      );
   end

   // result transfer
   assign rsp_bus.valid          = cell_valid[CELL_COUNT];
   assign cell_ready[CELL_COUNT] = rsp_bus.ready;
   assign rsp_bus.magnitude      = MAG_W'(cell_data[CELL_COUNT].root);

endmodule
